### design/fcr_pkg.sv
// shared types and constants of the framed command responder
package fcr_pkg;

  localparam logic [7:0] START_BYTE = 8'h24;

  localparam logic [7:0] CMD_LED       = 8'h20;
  localparam logic [7:0] CMD_INFO      = 8'h40;
  localparam logic [7:0] CMD_VERSION   = 8'h41;
  localparam logic [7:0] CMD_SERIAL    = 8'h42;
  localparam logic [7:0] CMD_DRV_KIND  = 8'h43;
  localparam logic [7:0] CMD_ERROR     = 8'h44;
  localparam logic [7:0] CMD_AMPLITUDE = 8'h45;
  localparam logic [7:0] CMD_SET_REPLY = 8'h50;
  localparam logic [7:0] CMD_SET_QUIET = 8'h51;
  localparam logic [7:0] CMD_RESET     = 8'hF0;

  localparam logic [2:0] REG_SERIAL    = 3'd0;
  localparam logic [2:0] REG_FW_MAJOR  = 3'd1;
  localparam logic [2:0] REG_FW_MINOR  = 3'd2;
  localparam logic [2:0] REG_DRV_KIND  = 3'd3;
  localparam logic [2:0] REG_DRV_ADDR  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_COUNT = 3'd2,
    PH_DATA  = 3'd3,
    PH_WAIT  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RESET = 2'd2
  } out_kind_t;

  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_REPLY = 2'd1,
    JOB_WRITE = 2'd2,
    JOB_RESET = 2'd3
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_REPLY = 2'd1,
    ST_WRITE = 2'd2,
    ST_RESET = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic      step;
    logic      push;
    logic      clear;
    out_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    job_t job;
    logic reply_done;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] serial_number;
    logic [7:0] firmware_major;
    logic [7:0] firmware_minor;
    logic [7:0] driver_kind;
    logic [7:0] driver_bus_address;
  } cfg_regs_t;

endpackage

### design/fcr_ctrl.sv
// controller state machine: request handshakes and result sequencing
module fcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output fcr_pkg::dp_cmd_t    cmd,
  input  fcr_pkg::dp_status_t status
);

  fcr_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    slot_free = !out_valid_r || !out_stall;
    unique case (state_r)
      fcr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.step = 1'b1;
          unique case (status.job)
            fcr_pkg::JOB_NONE:  state_nxt = fcr_pkg::ST_IDLE;
            fcr_pkg::JOB_REPLY: state_nxt = fcr_pkg::ST_REPLY;
            fcr_pkg::JOB_WRITE: state_nxt = fcr_pkg::ST_WRITE;
            fcr_pkg::JOB_RESET: state_nxt = fcr_pkg::ST_RESET;
            default:            state_nxt = fcr_pkg::ST_IDLE;
          endcase
        end
      end
      fcr_pkg::ST_REPLY: begin
        cmd.kind = fcr_pkg::KIND_REPLY;
        if (slot_free) begin
          cmd.push = 1'b1;
          if (status.reply_done) state_nxt = fcr_pkg::ST_IDLE;
        end
      end
      fcr_pkg::ST_WRITE: begin
        cmd.kind = fcr_pkg::KIND_WRITE;
        if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = fcr_pkg::ST_IDLE;
        end
      end
      fcr_pkg::ST_RESET: begin
        cmd.kind = fcr_pkg::KIND_RESET;
        if (slot_free) begin
          cmd.push  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = fcr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcr_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.push || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

  // a new request is never taken while results are still being produced
  a_no_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !cmd.push)
    else $error("result pushed in the cycle a request was taken");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid)
    else $error("pushed result not presented");

  a_silent_request: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && status.job == fcr_pkg::JOB_NONE) |=> !in_stall)
    else $error("request without results left the block busy");

  a_reset_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> state_r == fcr_pkg::ST_IDLE)
    else $error("reset request not followed by idle");

endmodule

### design/fcr_dp.sv
// datapath: deframer state, command execution, reply bytes and checksum
module fcr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcr_pkg::dp_cmd_t     cmd,
  output fcr_pkg::dp_status_t  status,
  input  fcr_pkg::cfg_regs_t   cfg,
  input  logic                 in_opcode,
  input  logic [7:0]           in_rx_byte,
  input  logic [1:0]           in_write_status,
  output fcr_pkg::out_kind_t   out_kind,
  output logic [7:0]           out_byte,
  output logic [7:0]           out_address,
  output logic                 out_last,
  output logic                 out_led_level
);

  fcr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] cmd_code_r, cmd_code_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] first_payload_r, first_payload_nxt;
  logic       payload_seen_r, payload_seen_nxt;
  logic [7:0] amplitude_r, amplitude_nxt;
  logic       led_on_r, led_on_nxt;
  logic [1:0] last_error_r, last_error_nxt;
  logic       reply_owed_r, reply_owed_nxt;

  logic [7:0] rep_cmd_r, rep_cmd_nxt;
  logic [2:0] rep_len_r, rep_len_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] s1_r, s1_nxt;
  logic [7:0] s2_r, s2_nxt;

  fcr_pkg::out_kind_t out_kind_r;
  logic [7:0] out_byte_r, out_address_r;
  logic       out_last_r, out_led_r;

  logic       exec;
  logic [7:0] fp_eff;
  logic [7:0] bl_dec;
  logic [3:0] len_p2, len_p3;
  logic [2:0] dpos;
  logic [7:0] data_byte, reply_byte;
  logic       reply_done;

  function automatic logic [7:0] add255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 9'd255) s = s - 9'd255;
    return s[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= fcr_pkg::PH_IDLE;
      cmd_code_r      <= '0;
      bytes_left_r    <= '0;
      first_payload_r <= '0;
      payload_seen_r  <= 1'b0;
      amplitude_r     <= '0;
      led_on_r        <= 1'b0;
      last_error_r    <= '0;
      reply_owed_r    <= 1'b0;
      rep_cmd_r       <= '0;
      rep_len_r       <= '0;
      idx_r           <= '0;
      s1_r            <= '0;
      s2_r            <= '0;
    end else begin
      phase_r         <= phase_nxt;
      cmd_code_r      <= cmd_code_nxt;
      bytes_left_r    <= bytes_left_nxt;
      first_payload_r <= first_payload_nxt;
      payload_seen_r  <= payload_seen_nxt;
      amplitude_r     <= amplitude_nxt;
      led_on_r        <= led_on_nxt;
      last_error_r    <= last_error_nxt;
      reply_owed_r    <= reply_owed_nxt;
      rep_cmd_r       <= rep_cmd_nxt;
      rep_len_r       <= rep_len_nxt;
      idx_r           <= idx_nxt;
      s1_r            <= s1_nxt;
      s2_r            <= s2_nxt;
    end
  end

  // reply byte sequencing
  always_comb begin
    len_p2 = {1'b0, rep_len_r} + 4'd2;
    len_p3 = {1'b0, rep_len_r} + 4'd3;
    dpos   = idx_r[2:0] - 3'd2;
    unique case (rep_cmd_r)
      fcr_pkg::CMD_LED: data_byte = {7'd0, led_on_r};
      fcr_pkg::CMD_INFO: begin
        unique case (dpos)
          3'd0:    data_byte = cfg.serial_number;
          3'd1:    data_byte = cfg.firmware_major;
          3'd2:    data_byte = cfg.firmware_minor;
          3'd3:    data_byte = cfg.driver_kind;
          default: data_byte = amplitude_r;
        endcase
      end
      fcr_pkg::CMD_VERSION:
        data_byte = (dpos == 3'd0) ? cfg.firmware_major : cfg.firmware_minor;
      fcr_pkg::CMD_SERIAL:    data_byte = cfg.serial_number;
      fcr_pkg::CMD_DRV_KIND:  data_byte = cfg.driver_kind;
      fcr_pkg::CMD_ERROR,
      fcr_pkg::CMD_SET_REPLY: data_byte = {6'd0, last_error_r};
      fcr_pkg::CMD_AMPLITUDE: data_byte = amplitude_r;
      default:                data_byte = '0;
    endcase
    if (idx_r == 4'd0)        reply_byte = rep_cmd_r;
    else if (idx_r == 4'd1)   reply_byte = {4'd0, len_p2};
    else if (idx_r == len_p2) reply_byte = s2_r;
    else if (idx_r == len_p3) reply_byte = s1_r;
    else                      reply_byte = data_byte;
    reply_done = (idx_r == len_p3);
  end

  always_comb begin
    phase_nxt         = phase_r;
    cmd_code_nxt      = cmd_code_r;
    bytes_left_nxt    = bytes_left_r;
    first_payload_nxt = first_payload_r;
    payload_seen_nxt  = payload_seen_r;
    amplitude_nxt     = amplitude_r;
    led_on_nxt        = led_on_r;
    last_error_nxt    = last_error_r;
    reply_owed_nxt    = reply_owed_r;
    rep_cmd_nxt       = rep_cmd_r;
    rep_len_nxt       = rep_len_r;
    idx_nxt           = idx_r;
    s1_nxt            = s1_r;
    s2_nxt            = s2_r;
    status.job        = fcr_pkg::JOB_NONE;
    status.reply_done = reply_done;
    exec              = 1'b0;
    bl_dec            = bytes_left_r - 8'd1;
    // the first data byte counts even when it also ends the packet
    fp_eff = (phase_r == fcr_pkg::PH_DATA && !payload_seen_r) ? in_rx_byte
                                                              : first_payload_r;

    if (cmd.step) begin
      if (in_opcode) begin
        if (phase_r == fcr_pkg::PH_WAIT) begin
          last_error_nxt = in_write_status;
          phase_nxt      = fcr_pkg::PH_IDLE;
          reply_owed_nxt = 1'b0;
          if (reply_owed_r) begin
            status.job  = fcr_pkg::JOB_REPLY;
            rep_cmd_nxt = fcr_pkg::CMD_SET_REPLY;
            rep_len_nxt = 3'd1;
          end
        end
      end else begin
        unique case (phase_r)
          fcr_pkg::PH_WAIT: phase_nxt = phase_r;
          fcr_pkg::PH_CMD: begin
            cmd_code_nxt = in_rx_byte;
            phase_nxt    = fcr_pkg::PH_COUNT;
          end
          fcr_pkg::PH_COUNT: begin
            bytes_left_nxt   = in_rx_byte;
            payload_seen_nxt = 1'b0;
            if (in_rx_byte == 8'd0) exec = 1'b1;
            else phase_nxt = fcr_pkg::PH_DATA;
          end
          fcr_pkg::PH_DATA: begin
            first_payload_nxt = fp_eff;
            payload_seen_nxt  = 1'b1;
            bytes_left_nxt    = bl_dec;
            if (bl_dec == 8'd0) exec = 1'b1;
          end
          default:
            phase_nxt = (in_rx_byte == fcr_pkg::START_BYTE) ? fcr_pkg::PH_CMD
                                                            : fcr_pkg::PH_IDLE;
        endcase
      end

      if (exec) begin
        phase_nxt   = fcr_pkg::PH_IDLE;
        rep_cmd_nxt = cmd_code_r;
        rep_len_nxt = 3'd1;
        unique case (cmd_code_r)
          fcr_pkg::CMD_LED: begin
            led_on_nxt = fp_eff[0];
            status.job = fcr_pkg::JOB_REPLY;
          end
          fcr_pkg::CMD_INFO: begin
            rep_len_nxt = 3'd5;
            status.job  = fcr_pkg::JOB_REPLY;
          end
          fcr_pkg::CMD_VERSION: begin
            rep_len_nxt = 3'd2;
            status.job  = fcr_pkg::JOB_REPLY;
          end
          fcr_pkg::CMD_SERIAL,
          fcr_pkg::CMD_DRV_KIND,
          fcr_pkg::CMD_ERROR,
          fcr_pkg::CMD_AMPLITUDE: status.job = fcr_pkg::JOB_REPLY;
          fcr_pkg::CMD_SET_REPLY,
          fcr_pkg::CMD_SET_QUIET: begin
            amplitude_nxt  = fp_eff;
            reply_owed_nxt = (cmd_code_r == fcr_pkg::CMD_SET_REPLY);
            phase_nxt      = fcr_pkg::PH_WAIT;
            status.job     = fcr_pkg::JOB_WRITE;
          end
          fcr_pkg::CMD_RESET: status.job = fcr_pkg::JOB_RESET;
          default:            status.job = fcr_pkg::JOB_NONE;
        endcase
      end
      idx_nxt = '0;
      s1_nxt  = '0;
      s2_nxt  = '0;
    end

    if (cmd.push && cmd.kind == fcr_pkg::KIND_REPLY) begin
      idx_nxt = idx_r + 4'd1;
      if (idx_r < len_p2) begin
        s1_nxt = add255(s1_r, reply_byte);
        s2_nxt = add255(s2_r, s1_nxt);
      end
    end

    // reset request: deframer and command state go back to reset values, but not the registers or the reply sequencer
    if (cmd.clear) begin
      phase_nxt         = fcr_pkg::PH_IDLE;
      cmd_code_nxt      = '0;
      bytes_left_nxt    = '0;
      first_payload_nxt = '0;
      payload_seen_nxt  = 1'b0;
      amplitude_nxt     = '0;
      led_on_nxt        = 1'b0;
      last_error_nxt    = '0;
      reply_owed_nxt    = 1'b0;
    end
  end

  // output register, loaded when the controller pushes a result
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind_r <= cmd.kind;
      out_led_r  <= led_on_r;
      unique case (cmd.kind)
        fcr_pkg::KIND_REPLY: begin
          out_byte_r    <= reply_byte;
          out_address_r <= '0;
          out_last_r    <= reply_done;
        end
        fcr_pkg::KIND_WRITE: begin
          out_byte_r    <= amplitude_r;
          out_address_r <= cfg.driver_bus_address;
          out_last_r    <= 1'b1;
        end
        default: begin
          out_byte_r    <= '0;
          out_address_r <= '0;
          out_last_r    <= 1'b1;
        end
      endcase
    end
  end

  assign out_kind      = out_kind_r;
  assign out_byte      = out_byte_r;
  assign out_address   = out_address_r;
  assign out_last      = out_last_r;
  assign out_led_level = out_led_r;

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r != 8'hFF && s2_r != 8'hFF)
    else $error("checksum sum not reduced mod 255");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.kind == fcr_pkg::KIND_REPLY) |-> idx_r <= len_p3)
    else $error("reply index ran past the checksum");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (phase_r == fcr_pkg::PH_IDLE && !led_on_r && !reply_owed_r))
    else $error("reset request did not clear the state");

endmodule

### design/framed_command_responder_top.sv
// top level: configuration registers, controller and datapath
//
// Framed command responder. Requests enter on the in_ channel: in_opcode 0
// carries a received serial byte in in_rx_byte, in_opcode 1 reports a finished
// driver write with its code in in_write_status. Results leave on the out_
// channel: reply bytes (command, count+2, data, Fletcher-16 high then low),
// driver write requests and reset requests; out_last marks the final result
// of a request.
// A request is taken only while the block is idle. One that causes no result
// leaves the block idle. Otherwise the controller enters a result state and
// pushes the results from the result sequencer into the output register one
// per cycle while out_ is not stalled; a nine-byte status reply is the longest.
// A stall on out_ holds the output register and the sequencer, and in_stall
// stays high until the last result has been loaded.
// The APB port holds five byte registers at byte addresses 0, 4, 8, 12, 16;
// write only while idle. rst_n (synchronous) clears all state but the output
// data fields and restores register defaults; no clearing pass follows.
module framed_command_responder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [7:0]          in_rx_byte,
  input  logic [1:0]          in_write_status,
  output logic                out_valid,
  input  logic                out_stall,
  output fcr_pkg::out_kind_t  out_kind,
  output logic [7:0]          out_byte,
  output logic [7:0]          out_address,
  output logic                out_last,
  output logic                out_led_level,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  fcr_pkg::cfg_regs_t  cfg_r;
  fcr_pkg::dp_cmd_t    cmd;
  fcr_pkg::dp_status_t status;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.serial_number      <= 8'd1;
      cfg_r.firmware_major     <= 8'd1;
      cfg_r.firmware_minor     <= 8'd7;
      cfg_r.driver_kind        <= 8'd0;
      cfg_r.driver_bus_address <= 8'd70;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fcr_pkg::REG_SERIAL:   cfg_r.serial_number      <= pwdata[7:0];
        fcr_pkg::REG_FW_MAJOR: cfg_r.firmware_major     <= pwdata[7:0];
        fcr_pkg::REG_FW_MINOR: cfg_r.firmware_minor     <= pwdata[7:0];
        fcr_pkg::REG_DRV_KIND: cfg_r.driver_kind        <= pwdata[7:0];
        fcr_pkg::REG_DRV_ADDR: cfg_r.driver_bus_address <= pwdata[7:0];
        default:               cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fcr_pkg::REG_SERIAL:   prdata = {24'd0, cfg_r.serial_number};
      fcr_pkg::REG_FW_MAJOR: prdata = {24'd0, cfg_r.firmware_major};
      fcr_pkg::REG_FW_MINOR: prdata = {24'd0, cfg_r.firmware_minor};
      fcr_pkg::REG_DRV_KIND: prdata = {24'd0, cfg_r.driver_kind};
      fcr_pkg::REG_DRV_ADDR: prdata = {24'd0, cfg_r.driver_bus_address};
      default:               prdata = '0;
    endcase
  end

  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  fcr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg_r),
    .in_opcode       (in_opcode),
    .in_rx_byte      (in_rx_byte),
    .in_write_status (in_write_status),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_address     (out_address),
    .out_last        (out_last),
    .out_led_level   (out_led_level)
  );

endmodule

### test/tb_top.sv
// testbench for the framed command responder: directed and random requests checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcr_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    out_kind_t  kind;
    logic [7:0] data;
    logic [7:0] addr;
    logic       last;
    logic       led;
  } result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [1:0]  in_write_status = 2'b00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_kind_t   out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  out_address;
  logic        out_last;
  logic        out_led_level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // shadow registers and responder state
  logic [7:0] reg_serial = 8'd1;
  logic [7:0] reg_major = 8'd1;
  logic [7:0] reg_minor = 8'd7;
  logic [7:0] reg_kind = 8'd0;
  logic [7:0] reg_addr = 8'd70;
  phase_t     st_phase = PH_IDLE;
  logic [7:0] st_cmd = 8'd0;
  logic [7:0] st_left = 8'd0;
  logic [7:0] st_first = 8'd0;
  logic       st_seen = 1'b0;
  logic [7:0] st_amp = 8'd0;
  logic       st_led = 1'b0;
  logic [1:0] st_err = 2'd0;
  logic       st_owed = 1'b0;

  result_t request_results[$];
  result_t expected_results[$];
  result_t head;
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;

  logic [7:0] known_cmds [10] = '{CMD_LED, CMD_INFO, CMD_VERSION, CMD_SERIAL, CMD_DRV_KIND,
                                  CMD_ERROR, CMD_AMPLITUDE, CMD_SET_REPLY, CMD_SET_QUIET,
                                  CMD_RESET};

  framed_command_responder_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_responder();
    st_phase = PH_IDLE;
    st_cmd = 8'd0;
    st_left = 8'd0;
    st_first = 8'd0;
    st_seen = 1'b0;
    st_amp = 8'd0;
    st_led = 1'b0;
    st_err = 2'd0;
    st_owed = 1'b0;
  endfunction

  function automatic void add_result(out_kind_t kind, logic [7:0] data, logic [7:0] addr);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.addr = addr;
    r.last = 1'b0;
    r.led = st_led;
    request_results.push_back(r);
  endfunction

  // command, count+2, data, then fletcher-16 high sum first
  function automatic void add_reply(logic [7:0] cmd, logic [7:0] d [5], int len);
    int sum1;
    int sum2;
    logic [7:0] cnt;
    cnt = 8'(len + 2);
    sum1 = cmd % 255;
    sum2 = sum1;
    sum1 = (sum1 + cnt) % 255;
    sum2 = (sum2 + sum1) % 255;
    add_result(KIND_REPLY, cmd, 8'd0);
    add_result(KIND_REPLY, cnt, 8'd0);
    for (int i = 0; i < len; i++) begin
      sum1 = (sum1 + d[i]) % 255;
      sum2 = (sum2 + sum1) % 255;
      add_result(KIND_REPLY, d[i], 8'd0);
    end
    add_result(KIND_REPLY, 8'(sum2), 8'd0);
    add_result(KIND_REPLY, 8'(sum1), 8'd0);
  endfunction

  function automatic void run_command();
    logic [7:0] d [5];
    d = '{default: 8'd0};
    st_phase = PH_IDLE;
    case (st_cmd)
      CMD_LED: begin
        st_led = st_first[0];
        d[0] = {7'd0, st_led};
        add_reply(CMD_LED, d, 1);
      end
      CMD_INFO: begin
        d = '{reg_serial, reg_major, reg_minor, reg_kind, st_amp};
        add_reply(CMD_INFO, d, 5);
      end
      CMD_VERSION: begin
        d[0] = reg_major;
        d[1] = reg_minor;
        add_reply(CMD_VERSION, d, 2);
      end
      CMD_SERIAL: begin
        d[0] = reg_serial;
        add_reply(CMD_SERIAL, d, 1);
      end
      CMD_DRV_KIND: begin
        d[0] = reg_kind;
        add_reply(CMD_DRV_KIND, d, 1);
      end
      CMD_ERROR: begin
        d[0] = {6'd0, st_err};
        add_reply(CMD_ERROR, d, 1);
      end
      CMD_AMPLITUDE: begin
        d[0] = st_amp;
        add_reply(CMD_AMPLITUDE, d, 1);
      end
      CMD_SET_REPLY, CMD_SET_QUIET: begin
        st_amp = st_first;
        add_result(KIND_WRITE, st_amp, reg_addr);
        st_owed = (st_cmd == CMD_SET_REPLY);
        st_phase = PH_WAIT;
      end
      CMD_RESET: begin
        add_result(KIND_RESET, 8'd0, 8'd0);
        clear_responder();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_request(logic op, logic [7:0] rx, logic [1:0] ws);
    logic [7:0] d [5];
    d = '{default: 8'd0};
    request_results.delete();
    if (op) begin
      // a completion only counts while a driver write is pending
      if (st_phase == PH_WAIT) begin
        st_err = ws;
        st_phase = PH_IDLE;
        if (st_owed) begin
          d[0] = {6'd0, st_err};
          add_reply(CMD_SET_REPLY, d, 1);
        end
        st_owed = 1'b0;
      end
    end else begin
      case (st_phase)
        PH_WAIT: ;
        PH_CMD: begin
          st_cmd = rx;
          st_phase = PH_COUNT;
        end
        PH_COUNT: begin
          st_left = rx;
          st_seen = 1'b0;
          if (rx == 8'd0) run_command();
          else st_phase = PH_DATA;
        end
        PH_DATA: begin
          if (!st_seen) begin
            st_first = rx;
            st_seen = 1'b1;
          end
          st_left = st_left - 8'd1;
          if (st_left == 8'd0) run_command();
        end
        default: st_phase = (rx == START_BYTE) ? PH_CMD : PH_IDLE;
      endcase
    end
    foreach (request_results[i]) begin
      head = request_results[i];
      head.last = (i == request_results.size() - 1);
      expected_results.push_back(head);
    end
  endfunction

  function automatic void report_mismatch(string what, int expv, int actv);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, expv, actv);
  endfunction

  // entered and left just after a rising edge; valid stays high when requests follow
  task automatic send_request(logic op, logic [7:0] rx, logic [1:0] ws);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= rx;
    in_write_status <= ws;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_request(op, rx, ws);
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [7:0] len);
    send_request(1'b0, START_BYTE, 2'($urandom));
    send_request(1'b0, cmd, 2'($urandom));
    send_request(1'b0, len, 2'($urandom));
    for (int i = 0; i < len; i++) send_request(1'b0, 8'($urandom), 2'($urandom));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SERIAL:   reg_serial = value;
      REG_FW_MAJOR: reg_major = value;
      REG_FW_MINOR: reg_minor = value;
      REG_DRV_KIND: reg_kind = value;
      REG_DRV_ADDR: reg_addr = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(cfg_regs_t regs);
    write_register(REG_SERIAL, regs.serial_number);
    write_register(REG_FW_MAJOR, regs.firmware_major);
    write_register(REG_FW_MINOR, regs.firmware_minor);
    write_register(REG_DRV_KIND, regs.driver_kind);
    write_register(REG_DRV_ADDR, regs.driver_bus_address);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_idle_noise();
    send_request(1'b0, 8'h00, 2'd0);
    send_request(1'b1, 8'hFF, 2'd3);
    send_request(1'b0, 8'hFF, 2'd3);
  endtask

  task automatic test_led_control();
    // empty packet: the kept byte is still zero from reset
    send_frame(CMD_LED, 8'd0);
    send_request(1'b0, START_BYTE, 2'd0);
    send_request(1'b0, CMD_LED, 2'd0);
    send_request(1'b0, 8'd2, 2'd0);
    send_request(1'b0, 8'hFF, 2'd0);
    send_request(1'b0, 8'h00, 2'd0);
  endtask

  task automatic test_status_queries();
    for (int c = CMD_INFO; c <= CMD_AMPLITUDE; c++) send_frame(8'(c), 8'd0);
  endtask

  task automatic test_amplitude_writes();
    send_request(1'b0, START_BYTE, 2'd0);
    send_request(1'b0, CMD_SET_REPLY, 2'd0);
    send_request(1'b0, 8'd1, 2'd0);
    send_request(1'b0, 8'hFF, 2'd0);
    // bytes are dropped while the write is pending
    send_request(1'b0, START_BYTE, 2'd0);
    send_request(1'b1, 8'h00, 2'd3);
    send_frame(CMD_SET_QUIET, 8'd0);
    send_request(1'b1, 8'hFF, 2'd0);
  endtask

  task automatic test_unknown_and_reset();
    send_frame(8'hFF, 8'd0);
    send_frame(CMD_RESET, 8'd0);
  endtask

  task automatic test_traffic_phase(int send_pct, int recv_pct, cfg_regs_t regs, int n_items);
    int sent;
    int len;
    int pick;
    bit held;
    logic [7:0] cmd;
    sent = 0;
    held = 1'b0;
    wait_for_drain();
    set_registers(regs);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    while (sent < n_items) begin
      if (st_phase == PH_WAIT) begin
        if ($urandom_range(9) < 7) begin
          send_request(1'b1, 8'($urandom), 2'($urandom));
          sent++;
        end else begin
          send_request(1'b0, 8'($urandom), 2'($urandom));
        end
      end else if (st_phase != PH_IDLE) begin
        // finish a broken packet with random bytes
        send_request(1'b0, 8'($urandom), 2'($urandom));
        sent++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          cmd = ($urandom_range(9) < 8) ? known_cmds[$urandom_range(9)] : 8'($urandom);
          len = ($urandom_range(19) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
          send_frame(cmd, 8'(len));
          sent += 3 + len;
        end else if (pick < 88) begin
          send_request(1'b0, 8'($urandom), 2'($urandom));
        end else if (pick < 94) begin
          send_request(1'b1, 8'($urandom), 2'($urandom));
        end else begin
          send_request(1'b0, START_BYTE, 2'($urandom));
          send_request(1'b0, 8'($urandom), 2'($urandom));
          sent += 2;
        end
      end
      if (!held && sent >= n_items / 2) begin
        wait_for_drain();
        held = 1'b1;
      end
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result byte", 0, out_byte);
      end else begin
        head = expected_results.pop_front();
        if (out_kind !== head.kind) report_mismatch("kind", head.kind, out_kind);
        if (out_byte !== head.data) report_mismatch("byte", head.data, out_byte);
        if (out_address !== head.addr) report_mismatch("address", head.addr, out_address);
        if (out_last !== head.last) report_mismatch("last", head.last, out_last);
        if (out_led_level !== head.led) report_mismatch("led level", head.led, out_led_level);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("framed_command_responder_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_noise();
    test_led_control();
    test_status_queries();
    test_amplitude_writes();
    test_unknown_and_reset();
    test_traffic_phase(0, 0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 60);
    test_traffic_phase(56, 0, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 60);
    test_traffic_phase(0, 56, cfg_regs_t'(40'({$urandom, $urandom})), 60);
    test_traffic_phase(12, 12, cfg_regs_t'(40'({$urandom, $urandom})), 60);
    wait_for_drain();
    if (mismatches == 0) begin
      $display("framed_command_responder_top verification clean");
    end else begin
      $display("framed_command_responder_top verification failed");
    end
    $finish;
  end

endmodule
